// File: rtl/b64d_pkg.sv
// Shared types, codes and helper functions of the base64url stream decoder.
package b64d_pkg;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_OK   = 2'd1,
    KIND_FAIL = 2'd2
  } kind_t;

  localparam logic [5:0] SEXTET_LOWER = 6'd26;
  localparam logic [5:0] SEXTET_DIGIT = 6'd52;
  localparam logic [5:0] SEXTET_DASH  = 6'd62;
  localparam logic [5:0] SEXTET_UNDER = 6'd63;

  typedef struct packed {
    logic       ok;
    logic [5:0] val;
  } sextet_t;

  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      nbytes;
    logic            status;
    logic            fail;
    logic [15:0]     count;
  } job_t;

  function automatic sextet_t decode_char(input logic [15:0] c);
    sextet_t r;
    r.ok  = 1'b1;
    r.val = 6'd0;
    if (c >= 16'h0041 && c <= 16'h005A) begin
      r.val = 6'(c - 16'h0041);
    end else if (c >= 16'h0061 && c <= 16'h007A) begin
      r.val = 6'(c - 16'h0061) + SEXTET_LOWER;
    end else if (c >= 16'h0030 && c <= 16'h0039) begin
      r.val = 6'(c - 16'h0030) + SEXTET_DIGIT;
    end else if (c == 16'h002D) begin
      r.val = SEXTET_DASH;
    end else if (c == 16'h005F) begin
      r.val = SEXTET_UNDER;
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

  function automatic logic [2:0][7:0] pack_bytes(input logic [5:0] s0, input logic [5:0] s1,
                                                 input logic [5:0] s2, input logic [5:0] s3);
    logic [2:0][7:0] b;
    b[0] = {s0, s1[5:4]};
    b[1] = {s1[3:0], s2[5:2]};
    b[2] = {s2[1:0], s3};
    return b;
  endfunction

endpackage

// File: rtl/b64d_front.sv
// Front end: decodes each character; a full group or the last one makes a request.
module b64d_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_write_en,
  input  logic [15:0]   cfg_write_data,
  input  logic          accept,
  input  logic [15:0]   char_code,
  input  logic          is_last,
  output logic          push,
  output b64d_pkg::job_t job
);
  import b64d_pkg::*;

  logic [15:0]     capacity;
  logic [2:0][5:0] held, held_next;
  logic [1:0]      fill, fill_next;
  logic [15:0]     written, written_next;
  logic            failed, failed_next;

  sextet_t         dec;
  logic            group_done;
  logic            tail;
  logic [1:0]      nb;
  logic [5:0]      s0, s1, s2, s3;
  logic [16:0]     sum;
  logic            emit;

  always_comb begin
    dec          = decode_char(char_code);
    held_next    = held;
    fill_next    = fill;
    written_next = written;
    failed_next  = failed;
    group_done   = 1'b0;
    nb           = 2'd0;
    s0 = 6'd0; s1 = 6'd0; s2 = 6'd0; s3 = 6'd0;
    emit         = 1'b0;

    if (!failed) begin
      if (!dec.ok) begin
        failed_next = 1'b1;
      end else if (fill != 2'd3) begin
        held_next[fill] = dec.val;
        fill_next       = fill + 2'd1;
      end else begin
        fill_next  = 2'd0;
        group_done = 1'b1;
      end
    end

    tail = is_last && !failed_next && (fill_next != 2'd0);

    if (group_done) begin
      nb = 2'd3;
      s0 = held[0]; s1 = held[1]; s2 = held[2]; s3 = dec.val;
    end else if (tail) begin
      s0 = held_next[0];
      s1 = held_next[1];
      s2 = (fill_next == 2'd3) ? held_next[2] : 6'd0;
      if (fill_next == 2'd1) begin
        failed_next = 1'b1;
      end else begin
        nb = fill_next - 2'd1;
      end
    end

    sum = {1'b0, written} + {15'd0, nb};
    if (nb != 2'd0) begin
      if (sum > {1'b0, capacity}) begin
        failed_next = 1'b1;
      end else begin
        written_next = sum[15:0];
        emit         = 1'b1;
      end
    end

    job.bytes  = pack_bytes(s0, s1, s2, s3);
    job.nbytes = emit ? nb : 2'd0;
    job.status = is_last;
    job.fail   = failed_next;
    job.count  = written_next;
    push       = accept && (emit || is_last);

    if (is_last) begin
      held_next    = '0;
      fill_next    = 2'd0;
      written_next = 16'd0;
      failed_next  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= 16'hFFFF;
      held     <= '0;
      fill     <= 2'd0;
      written  <= 16'd0;
      failed   <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        capacity <= cfg_write_data;
      end
      if (accept) begin
        held    <= held_next;
        fill    <= fill_next;
        written <= written_next;
        failed  <= failed_next;
      end
    end
  end

endmodule

// File: rtl/b64d_queue.sv
// Short queue of output requests between the front and back ends.
module b64d_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  b64d_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output b64d_pkg::job_t head
);
  import b64d_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          slots [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst) full |-> !push)
    else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) empty |-> !pop)
    else $error("pop from empty queue");

endmodule

// File: rtl/b64d_back.sv
// Back end: walks the head request of the queue; one result per cycle while non-empty and out_ready is high.
module b64d_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           empty,
  input  b64d_pkg::job_t head,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [1:0]     kind,
  output logic [7:0]     data_byte,
  output logic [15:0]    byte_count,
  output logic           end_of_run
);
  import b64d_pkg::*;

  logic [1:0] idx, idx_next;
  logic       is_data;

  always_comb begin
    out_valid = !empty;
    is_data   = (idx < head.nbytes);
    if (is_data) begin
      kind       = KIND_DATA;
      data_byte  = head.bytes[idx];
      byte_count = 16'd0;
      end_of_run = (idx == head.nbytes - 2'd1) && !head.status;
    end else begin
      kind       = head.fail ? KIND_FAIL : KIND_OK;
      data_byte  = 8'd0;
      byte_count = head.count;
      end_of_run = 1'b1;
    end
    pop      = out_valid && out_ready && end_of_run;
    idx_next = idx;
    if (out_valid && out_ready) begin
      idx_next = end_of_run ? 2'd0 : idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 2'd0;
    end else begin
      idx <= idx_next;
    end
  end

  a_status_ends_run: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind != KIND_DATA) |-> end_of_run)
    else $error("status result not last of its run");
  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (idx == $past(idx)))
    else $error("result index moved while stalled");

endmodule

// File: rtl/base64url_stream_decoder.sv
// Top level of the base64url stream decoder.
//
// Usage: characters of a filename-safe Base64 string (no padding) arrive one
// UTF-16 code unit per request on the input channel (in_valid/in_ready,
// char_code, is_last). Results leave on the output channel (out_valid/
// out_ready, kind, data_byte, byte_count, end_of_run): data bytes, and after
// the character marked last one status result (done or failed) with the byte
// count. end_of_run marks the last result caused by one input character.
// One character is taken per cycle while in_ready is high; the front end
// decodes it in the accepting cycle and queues its results, which appear
// from the next cycle on. A character may produce up to four results, which
// the back end emits one per cycle while out_ready is high.
// When the receiver stalls, the queue of QUEUE_DEPTH requests fills and
// in_ready drops; results are never lost or dropped.
// cfg_write_en/cfg_write_data set the output capacity; users write it while
// idle, unchecked by the block. Reset clears state and queue; capacity 65535.
module base64url_stream_decoder #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_en,
  input  logic [15:0] cfg_write_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] char_code,
  input  logic        is_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [7:0]  data_byte,
  output logic [15:0] byte_count,
  output logic        end_of_run
);
  import b64d_pkg::*;

  logic accept;
  logic push, full, pop, empty;
  job_t push_job, head;

  assign in_ready = !full;
  assign accept   = in_valid && in_ready;

  b64d_front u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .accept         (accept),
    .char_code      (char_code),
    .is_last        (is_last),
    .push           (push),
    .job            (push_job)
  );

  b64d_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (full),
    .pop      (pop),
    .empty    (empty),
    .head     (head)
  );

  b64d_back u_back (
    .clk        (clk),
    .rst        (rst),
    .empty      (empty),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .kind       (kind),
    .data_byte  (data_byte),
    .byte_count (byte_count),
    .end_of_run (end_of_run)
  );

endmodule
